// ===== design/nsll_pkg.sv =====
package nsll_pkg;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_PRIOR = 1'b0,
    CFG_NOISE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [39:0] left_sum;
    logic        [39:0] left_square_sum;
    logic signed [39:0] total_sum;
    logic        [39:0] total_square_sum;
    logic        [20:0] total_count;
    logic        [19:0] left_index;
    logic               score_left;
    logic               whole_node;
  } nsll_item_t;

  typedef struct packed {
    logic signed [47:0] log_likelihood;
    logic               count_underflow;
  } nsll_score_t;

  localparam int Y_W   = 41;   // side sum / square sum difference
  localparam int YSQ_W = 82;   // y*y
  localparam int QA_W  = 56;   // |q| * 2^15
  localparam int NUM_W = 126;  // divider numerator
  localparam int DEN_W = 64;
  localparam int QUO_W = 63;   // quotient, capped at 2^62
  localparam int LN_W  = 24;   // ln result, signed Q16

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [QUO_W-1:0] QUO_CAP = 63'h4000000000000000;
  localparam logic signed [63:0] T4_CAP  = 64'sh2000000000000000;
  localparam logic signed [63:0] OUT_MAX = 64'sh00007FFFFFFFFFFF;
  localparam logic signed [63:0] OUT_MIN = 64'shFFFF800000000000;

  // log2(1+f) at 16 segments, Q16
  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

endpackage

// ===== design/nsll_if.sv =====
interface nsll_item_if import nsll_pkg::*;;
  logic       valid;
  logic       ready;
  nsll_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nsll_score_if import nsll_pkg::*;;
  logic        valid;
  logic        ready;
  nsll_score_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/nsll_log.sv =====
module nsll_log import nsll_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [63:0]             x,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic signed [LN_W-1:0]  ln,
  output logic [SIDE_W-1:0]       out_side
);

  logic [4:0] valid;

  // stage 1: leading one per 16-bit chunk
  logic [63:0]       x1;
  logic [3:0]        nz1;
  logic [3:0]        pos1 [4];
  logic [SIDE_W-1:0] side1;
  logic [3:0]        pos_c [4];

  // stage 2: normalize
  logic [5:0]        p2;
  logic [31:0]       frac2;
  logic [SIDE_W-1:0] side2;
  logic [5:0]        p_c;
  logic [63:0]       shifted;

  // stage 3: table and interpolation
  logic signed [LN_W-1:0] l2_3;
  logic [SIDE_W-1:0]      side3;
  logic [16:0]            tab_lo;
  logic [16:0]            tab_hi;
  logic [44:0]            interp_prod;
  logic [16:0]            interp;
  logic signed [7:0]      exp_c;

  // stage 4: scale by ln2
  logic signed [56:0] prod4;
  logic [SIDE_W-1:0]  side4;
  logic signed [56:0] rounded;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pos_c[c] = 4'd0;
      for (int b = 0; b < 16; b++) begin
        if (x[c*16+b]) pos_c[c] = 4'(b);
      end
    end
  end

  always_comb begin
    if (nz1[3]) begin
      p_c = {2'd3, pos1[3]};
    end else if (nz1[2]) begin
      p_c = {2'd2, pos1[2]};
    end else if (nz1[1]) begin
      p_c = {2'd1, pos1[1]};
    end else begin
      p_c = {2'd0, pos1[0]};
    end
    shifted = x1 << (6'd63 - p_c);
  end

  always_comb begin
    tab_lo      = LOG2_TAB[frac2[31:28]];
    tab_hi      = LOG2_TAB[{1'b0, frac2[31:28]} + 5'd1];
    interp_prod = 45'(tab_hi - tab_lo) * 45'(frac2[27:0]);
    interp      = tab_lo + 17'(interp_prod >> 28);
    exp_c       = $signed({2'b00, p2}) - 8'sd16;
  end

  assign rounded = prod4 + 57'sd2147483648;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      for (int c = 0; c < 4; c++) begin
        nz1[c]  <= |x[c*16 +: 16];
        pos1[c] <= pos_c[c];
      end
      side1 <= in_side;

      p2    <= p_c;
      frac2 <= shifted[62:31];
      side2 <= side1;

      l2_3  <= {exp_c, 16'd0} + $signed({7'd0, interp});
      side3 <= side2;

      prod4 <= l2_3 * $signed({1'b0, LN2_Q32});
      side4 <= side3;

      ln       <= rounded[55:32];
      out_side <= side4;
    end
  end

  assign out_valid = valid[4];

endmodule

// ===== design/nsll_div.sv =====
module nsll_div import nsll_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] out_side
);

  // one quotient bit per stage; a quotient of 2^62 or more is caught up front
  localparam int STEPS = QUO_W - 1;

  logic [STEPS:0]     valid;
  logic [STEPS:0]     sat;
  logic [DEN_W-1:0]   rem   [STEPS+1];
  logic [STEPS-1:0]   low   [STEPS+1];
  logic [STEPS-1:0]   quo_r [STEPS+1];
  logic [DEN_W-1:0]   dv    [STEPS+1];
  logic [SIDE_W-1:0]  side  [STEPS+1];
  logic [DEN_W-1:0]   rem_next [STEPS+1];
  logic [STEPS:0]     ge;

  always_comb begin
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    rem_next[0] = '0;
    ge[0]       = 1'b0;
    for (int i = 1; i <= STEPS; i++) begin
      trial       = {rem[i-1], low[i-1][STEPS-1]};
      diff        = trial - {1'b0, dv[i-1]};
      ge[i]       = trial >= {1'b0, dv[i-1]};
      rem_next[i] = ge[i] ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num[NUM_W-1:STEPS];
      sat[0]   <= num[NUM_W-1:STEPS] >= den;
      low[0]   <= num[STEPS-1:0];
      quo_r[0] <= '0;
      dv[0]    <= den;
      side[0]  <= in_side;
      for (int i = 1; i <= STEPS; i++) begin
        rem[i]   <= rem_next[i];
        sat[i]   <= sat[i-1];
        low[i]   <= {low[i-1][STEPS-2:0], 1'b0};
        quo_r[i] <= {quo_r[i-1][STEPS-2:0], ge[i]};
        dv[i]    <= dv[i-1];
        side[i]  <= side[i-1];
      end
    end
  end

  assign out_valid = valid[STEPS];
  assign quo       = sat[STEPS] ? QUO_CAP : {1'b0, quo_r[STEPS]};
  assign out_side  = side[STEPS];

endmodule

// ===== design/normal_split_log_likelihood.sv =====
// Throughput: one request per cycle while the output is not stalled; the 63-stage
// dividers (two in parallel feeding a third) and the 5-stage log units are fully
// pipelined, so every stage advances together.
// A stalled output freezes the whole pipeline; ready is low only then.
// Reset (rst, synchronous) clears all valid bits and sets both variances to 1.0.
module normal_split_log_likelihood import nsll_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  nsll_item_if.sink   item,
  nsll_score_if.source score
);

  localparam int NBW = COUNT_BITS + 1;

  typedef struct packed {
    logic [NBW-1:0]   nb;
    logic [YSQ_W-1:0] ysq;
    logic [QA_W-1:0]  numa;
    logic             qpos;
    logic [63:0]      d;
  } log_side_t;

  typedef struct packed {
    logic signed [63:0] t12;
    logic [63:0]        d;
    logic               flag;
  } sq_side_t;

  typedef struct packed {
    logic signed [63:0] t123;
    logic               usat;
    logic               flag;
  } fin_side_t;

  logic [31:0] prior;
  logic [31:0] noise;
  logic [31:0] s_eff;
  logic        advance;

  // stage 1
  logic                 v1;
  logic [NBW-1:0]       nb1;
  logic signed [Y_W-1:0] y1;
  logic signed [Y_W-1:0] q1;
  logic                 flag1;
  logic [NBW-1:0]       tn_c;
  logic [NBW-1:0]       ln_c;
  logic [NBW-1:0]       nb_c;
  logic signed [Y_W-1:0] y_c;
  logic signed [Y_W-1:0] q_c;
  logic                 flag_c;

  // stage 2
  logic              v2;
  logic [NBW-1:0]    nb2;
  logic [Y_W-1:0]    qmag2;
  logic              qpos2;
  logic              flag2;
  logic [NBW+31:0]   ntau2;
  logic [63:0]       pl2;
  logic [40:0]       pm2;
  logic [17:0]       ph2;
  logic [Y_W-1:0]    ymag_c;
  logic [Y_W-1:0]    qmag_c;

  // stage 3
  logic             v3;
  logic             flag3;
  log_side_t        side3;
  logic [65:0]      dsum_c;

  // log units
  logic                   logd_valid;
  logic                   logs_valid;
  logic signed [LN_W-1:0] ln_d;
  logic signed [LN_W-1:0] ln_s;
  log_side_t              side4_in;
  logic                   flag4_in;

  // stage 4
  logic                   v4;
  logic [YSQ_W-1:0]       ysq4;
  logic [QA_W-1:0]        numa4;
  logic                   qpos4;
  sq_side_t               bside_in;
  logic signed [NBW:0]    one_minus_c;
  logic signed [NBW+LN_W:0] m1_c;
  logic signed [63:0]     t1_c;
  logic signed [63:0]     t2_c;

  // first dividers
  logic             a_valid;
  logic             b_valid;
  logic [QUO_W-1:0] qa;
  logic [QUO_W-1:0] qb;
  logic             qpos_out;
  sq_side_t         bside;

  // stages 5 and 6
  logic               v5;
  logic signed [63:0] t123_5;
  logic [63:0]        ul5;
  logic [61:0]        uh5;
  logic [63:0]        d5;
  logic               flag5;
  logic               usat5;
  logic signed [63:0] t3_c;
  logic               v6;
  logic [NUM_W-1:0]   numc6;
  logic [63:0]        d6;
  fin_side_t          cside_in;

  // last divider and output
  logic               c_valid;
  logic [QUO_W-1:0]   qc;
  fin_side_t          cside;
  logic signed [63:0] t4_c;
  logic signed [63:0] total_c;
  logic signed [47:0] ll_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      prior <= 32'd65536;
      noise <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PRIOR: prior <= cfg_data;
        CFG_NOISE: noise <= cfg_data;
      endcase
    end
  end

  assign s_eff   = (noise == 32'd0) ? 32'd1 : noise;
  assign advance = !score.valid || score.ready;
  assign item.ready = advance;

  // side selection
  always_comb begin
    tn_c   = NBW'(item.payload.total_count);
    ln_c   = NBW'(COUNT_BITS'(item.payload.left_index)) + NBW'(1);
    flag_c = 1'b0;
    if (item.payload.whole_node) begin
      nb_c = tn_c;
      y_c  = Y_W'(item.payload.total_sum);
      q_c  = $signed({1'b0, item.payload.total_square_sum});
    end else if (item.payload.score_left) begin
      nb_c = ln_c;
      y_c  = Y_W'(item.payload.left_sum);
      q_c  = $signed({1'b0, item.payload.left_square_sum});
    end else begin
      if (tn_c < ln_c) begin
        nb_c   = '0;
        flag_c = 1'b1;
      end else begin
        nb_c = tn_c - ln_c;
      end
      y_c = Y_W'(item.payload.total_sum) - Y_W'(item.payload.left_sum);
      q_c = $signed({1'b0, item.payload.total_square_sum})
          - $signed({1'b0, item.payload.left_square_sum});
    end
  end

  assign ymag_c = y1[Y_W-1] ? Y_W'(-y1) : Y_W'(y1);
  assign qmag_c = q1[Y_W-1] ? Y_W'(-q1) : Y_W'(q1);

  // D = nb*tau + s, saturated to 64 bits
  assign dsum_c = 66'(ntau2) + 66'(s_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= item.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= logd_valid;
      v5 <= b_valid;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nb1   <= nb_c;
      y1    <= y_c;
      q1    <= q_c;
      flag1 <= flag_c;

      nb2   <= nb1;
      qmag2 <= qmag_c;
      qpos2 <= !q1[Y_W-1];
      flag2 <= flag1;
      ntau2 <= nb1 * prior;
      pl2   <= ymag_c[31:0] * ymag_c[31:0];
      pm2   <= ymag_c[31:0] * ymag_c[40:32];
      ph2   <= ymag_c[40:32] * ymag_c[40:32];

      flag3      <= flag2;
      side3.nb   <= nb2;
      side3.ysq  <= YSQ_W'(pl2) + (YSQ_W'(pm2) << 33) + (YSQ_W'(ph2) << 64);
      side3.numa <= QA_W'(qmag2) << 15;
      side3.qpos <= qpos2;
      side3.d    <= (|dsum_c[65:64]) ? '1 : dsum_c[63:0];
    end
  end

  nsll_log #(.SIDE_W($bits(log_side_t))) u_log_d (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v3),
    .x         (side3.d),
    .in_side   (side3),
    .out_valid (logd_valid),
    .ln        (ln_d),
    .out_side  (side4_in)
  );

  nsll_log #(.SIDE_W(1)) u_log_s (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v3),
    .x         (64'(s_eff)),
    .in_side   (flag3),
    .out_valid (logs_valid),
    .ln        (ln_s),
    .out_side  (flag4_in)
  );

  // T1 = round((1-nb)*ln(s)/2), T2 = round(-ln(D)/2)
  always_comb begin
    one_minus_c = $signed((NBW+1)'(1)) - $signed({1'b0, side4_in.nb});
    m1_c        = one_minus_c * ln_s;
    t1_c        = (64'(m1_c) + 64'sd1) >>> 1;
    t2_c        = (64'sd1 - 64'(ln_d)) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ysq4          <= side4_in.ysq;
      numa4         <= side4_in.numa;
      qpos4         <= side4_in.qpos;
      bside_in.t12  <= t1_c + t2_c;
      bside_in.d    <= side4_in.d;
      bside_in.flag <= flag4_in;
    end
  end

  nsll_div #(.SIDE_W(1)) u_div_q (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v4),
    .num       (NUM_W'(numa4)),
    .den       (DEN_W'(s_eff)),
    .in_side   (qpos4),
    .out_valid (a_valid),
    .quo       (qa),
    .out_side  (qpos_out)
  );

  nsll_div #(.SIDE_W($bits(sq_side_t))) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v4),
    .num       (NUM_W'(ysq4)),
    .den       (DEN_W'(s_eff)),
    .in_side   (bside_in),
    .out_valid (b_valid),
    .quo       (qb),
    .out_side  (bside)
  );

  // T3 is negative for a nonnegative square sum
  assign t3_c = qpos_out ? -$signed(64'(qa)) : $signed(64'(qa));

  always_ff @(posedge clk) begin
    if (advance) begin
      t123_5 <= bside.t12 + t3_c;
      ul5    <= qb[31:0] * prior;
      uh5    <= qb[61:32] * prior;
      d5     <= bside.d;
      flag5  <= bside.flag;
      usat5  <= qb == QUO_CAP;

      numc6         <= NUM_W'(ul5) + (NUM_W'(uh5) << 32);
      d6            <= d5;
      cside_in.t123 <= t123_5;
      cside_in.usat <= usat5;
      cside_in.flag <= flag5;
    end
  end

  nsll_div #(.SIDE_W($bits(fin_side_t))) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v6),
    .num       (numc6),
    .den       (d6),
    .in_side   (cside_in),
    .out_valid (c_valid),
    .quo       (qc),
    .out_side  (cside)
  );

  always_comb begin
    t4_c    = cside.usat ? T4_CAP : $signed(64'(qc >> 1));
    total_c = cside.t123 + t4_c;
    if (total_c > OUT_MAX) begin
      ll_c = OUT_MAX[47:0];
    end else if (total_c < OUT_MIN) begin
      ll_c = OUT_MIN[47:0];
    end else begin
      ll_c = total_c[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score.valid <= 1'b0;
    end else if (advance) begin
      score.valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      score.payload.log_likelihood  <= ll_c;
      score.payload.count_underflow <= cside.flag;
    end
  end

  a_div_aligned: assert property (@(posedge clk) disable iff (rst) a_valid == b_valid)
    else $error("square-sum and sum dividers out of step");

  a_log_aligned: assert property (@(posedge clk) disable iff (rst) logd_valid == logs_valid)
    else $error("log units out of step");

  a_reset_clears: assert property (@(posedge clk) rst |=> !score.valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(v1) && $stable(nb1) && $stable(y1))
    else $error("first stage changed during stall");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import nsll_pkg::*;

  localparam int LATENCY = 138;
  localparam int SETTLE = LATENCY + 20;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = CFG_PRIOR;
  logic [31:0] cfg_data = '0;

  nsll_item_if item_bus ();
  nsll_score_if score_bus ();

  normal_split_log_likelihood dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_bus.sink),
    .score(score_bus.source)
  );

  always #6 clk = ~clk;

  // local copy of the variance registers
  logic [31:0] prior_var = 32'd65536;
  logic [31:0] noise_var = 32'd65536;

  nsll_score_t pending_scores[$];
  int errors = 0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  initial begin
    item_bus.valid = 1'b0;
    item_bus.payload = '0;
    score_bus.ready = 1'b0;
  end

  // floor(a*b/c), capped at 2^62
  function automatic logic [63:0] mul_div_cap(logic [127:0] a, logic [127:0] b,
                                              logic [127:0] c);
    logic [127:0] q;
    q = (a * b) / c;
    if (q >= (128'd1 << 62)) return 64'd1 << 62;
    return q[63:0];
  endfunction

  // natural log of Q16.16 x >= 1, Q16 result
  function automatic longint ln_fixed(logic [63:0] x);
    int p;
    logic [63:0] frac;
    logic [3:0] seg;
    logic [63:0] r;
    logic [63:0] interp;
    longint l2;
    p = 63;
    while (p > 0 && !x[p]) p--;
    frac = (p >= 32) ? (x >> (p - 32)) : (x << (32 - p));
    seg = frac[31:28];
    r = {36'd0, frac[27:0]};
    interp = 64'(LOG2_TAB[seg]) +
             (((64'(LOG2_TAB[seg + 1]) - 64'(LOG2_TAB[seg])) * r) >> 28);
    l2 = (longint'(p) - 16) * 65536 + longint'(interp);
    return (l2 * longint'({32'd0, LN2_Q32}) + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic nsll_score_t split_score(nsll_item_t it);
    nsll_score_t res;
    logic [63:0] nb, total_n, left_n, s2, den, ymag, qmag, u;
    logic [127:0] prod;
    longint ysum, ysq, t1, t2, t3, t4, sum;
    total_n = 64'(it.total_count);
    left_n = 64'(it.left_index) + 1;
    s2 = (noise_var == 0) ? 64'd1 : 64'(noise_var);
    res.count_underflow = 1'b0;
    if (it.whole_node) begin
      nb = total_n;
      ysum = longint'(it.total_sum);
      ysq = longint'({24'd0, it.total_square_sum});
    end else if (it.score_left) begin
      nb = left_n;
      ysum = longint'(it.left_sum);
      ysq = longint'({24'd0, it.left_square_sum});
    end else begin
      if (total_n < left_n) begin
        nb = 0;
        res.count_underflow = 1'b1;
      end else begin
        nb = total_n - left_n;
      end
      ysum = longint'(it.total_sum) - longint'(it.left_sum);
      ysq = longint'({24'd0, it.total_square_sum}) - longint'({24'd0, it.left_square_sum});
    end
    prod = 128'(nb) * 128'(prior_var) + 128'(s2);
    den = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    t1 = ((1 - longint'(nb)) * ln_fixed(s2) + 1) >>> 1;
    t2 = (-ln_fixed(den) + 1) >>> 1;
    qmag = (ysq < 0) ? 64'(-ysq) : 64'(ysq);
    t3 = longint'(mul_div_cap(128'(qmag), 128'd32768, 128'(s2)));
    if (ysq >= 0) t3 = -t3;
    ymag = (ysum < 0) ? 64'(-ysum) : 64'(ysum);
    u = mul_div_cap(128'(ymag), 128'(ymag), 128'(s2));
    if (u >= (64'd1 << 62)) t4 = 64'sd1 <<< 61;
    else t4 = longint'(mul_div_cap(128'(u), 128'(prior_var), 128'(den)) >> 1);
    sum = t1 + t2 + t3 + t4;
    if (sum > OUT_MAX) sum = OUT_MAX;
    if (sum < OUT_MIN) sum = OUT_MIN;
    res.log_likelihood = sum[47:0];
    return res;
  endfunction

  // keeps valid high; callers lower it only for a gap
  task automatic send_request(nsll_item_t it);
    item_bus.valid <= 1'b1;
    item_bus.payload <= it;
    do @(posedge clk); while (!item_bus.ready);
    pending_scores.push_back(split_score(it));
  endtask

  task automatic pause_sender(int cycles);
    item_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    pause_sender(0);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_variances(logic [31:0] prior, logic [31:0] noise);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRIOR;
    cfg_data <= prior;
    @(posedge clk);
    cfg_index <= CFG_NOISE;
    cfg_data <= noise;
    @(posedge clk);
    cfg_write <= 1'b0;
    prior_var = prior;
    noise_var = noise;
  endtask

  function automatic logic [39:0] rand40();
    logic [39:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = v >> $urandom_range(16, 39);
      1: v = v >> $urandom_range(4, 16);
      default: ;
    endcase
    return v;
  endfunction

  function automatic nsll_item_t random_request();
    nsll_item_t it;
    logic [39:0] mag;
    it.total_count = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 1048576))
                                                 : 21'($urandom_range(0, 300));
    if ($urandom_range(0, 7) != 0 && it.total_count != 0)
      it.left_index = 20'($urandom_range(0, it.total_count - 1));
    else
      it.left_index = 20'($urandom);
    it.left_sum = rand40();
    if ($urandom_range(0, 1)) it.left_sum = -it.left_sum;
    it.total_sum = rand40();
    if ($urandom_range(0, 1)) it.total_sum = -it.total_sum;
    it.left_square_sum = rand40();
    mag = rand40();
    // mostly a node total at least as large as the left part
    if ($urandom_range(0, 7) != 0 && mag <= ~it.left_square_sum)
      it.total_square_sum = it.left_square_sum + mag;
    else
      it.total_square_sum = mag;
    it.score_left = $urandom_range(0, 1);
    it.whole_node = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic random_burst_run(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < count) begin
        send_request(random_request());
        burst--;
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  function automatic nsll_item_t make_request(logic signed [39:0] ls, logic [39:0] lq,
      logic signed [39:0] ts, logic [39:0] tq, logic [20:0] tc, logic [19:0] li,
      logic sl, logic wn);
    nsll_item_t it;
    it.left_sum = ls;
    it.left_square_sum = lq;
    it.total_sum = ts;
    it.total_square_sum = tq;
    it.total_count = tc;
    it.left_index = li;
    it.score_left = sl;
    it.whole_node = wn;
    return it;
  endfunction

  task automatic test_directed();
    localparam logic signed [39:0] SMAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] SMIN = 40'sh80_0000_0000;
    localparam logic [39:0] QMAX = 40'hFF_FFFF_FFFF;
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 1));           // empty node
    send_request(make_request(0, 0, 0, 0, 1, 0, 1, 0));
    send_request(make_request(65536, 65536, 131072, 196608, 2, 0, 1, 0));
    send_request(make_request(65536, 65536, 131072, 196608, 2, 0, 0, 0));
    send_request(make_request(65536, 65536, 131072, 196608, 2, 0, 0, 1));
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0));           // right count underflow
    send_request(make_request(0, 0, 0, 0, 5, 20'hFFFFF, 0, 0));
    send_request(make_request(0, QMAX, 0, 0, 3, 0, 0, 0));        // negative right squares
    send_request(make_request(SMAX, QMAX, SMIN, QMAX, 21'h100000, 20'hFFFFF, 0, 0));
    send_request(make_request(SMAX, QMAX, SMAX, QMAX, 21'h1FFFFF, 20'hFFFFF, 1, 0));
    send_request(make_request(SMIN, 0, SMIN, QMAX, 21'h1FFFFF, 0, 0, 1));
    send_request(make_request(SMIN, QMAX, SMAX, 0, 21'h100000, 20'h7FFFF, 0, 0));
    send_request(make_request(SMAX, 0, SMIN, 0, 21'd10, 20'd3, 1, 0));
    send_request(make_request(-40'sd65536, 40'd65536, 40'sd65536, 40'd65536, 10, 3, 0, 0));
    send_request(make_request(SMAX, QMAX, SMAX, QMAX, 21'h100000, 20'hFFFFF, 1, 1));
  endtask

  task automatic test_register_extremes();
    set_variances(32'd0, 32'd0);                 // zero noise acts as one code
    test_directed();
    random_burst_run(150);
    set_variances(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_directed();
    random_burst_run(150);
    set_variances(32'hFFFF_FFFF, 32'd1);
    test_directed();
    random_burst_run(100);
    set_variances(32'd1, 32'hFFFF_FFFF);
    random_burst_run(100);
  endtask

  task automatic test_random_settings();
    repeat (6) begin
      set_variances($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 20),
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 20));
      random_burst_run(80);
    end
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (300) send_request(random_request());
    random_burst_run(100);
  endtask

  // receiver: a randomly chosen stall pattern, redrawn whenever the phase counter wraps, plus one long hold-off
  initial begin
    int mode;
    int phase;
    mode = 0;
    phase = 0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        score_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (phase == 0) mode = $urandom_range(0, 3);
        phase = (phase + 1) % 64;
        case (mode)
          0: score_bus.ready <= 1'b1;
          1: score_bus.ready <= ($urandom_range(0, 3) != 0);
          2: score_bus.ready <= $urandom_range(0, 1);
          default: score_bus.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    nsll_score_t want;
    if (!rst && score_bus.valid && score_bus.ready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score, actual %h", $time, score_bus.payload);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (score_bus.payload.log_likelihood !== want.log_likelihood) begin
          $display("%0t: log_likelihood expected %0d actual %0d", $time,
                   want.log_likelihood, score_bus.payload.log_likelihood);
          errors++;
        end
        if (score_bus.payload.count_underflow !== want.count_underflow) begin
          $display("%0t: count_underflow expected %0b actual %0b", $time,
                   want.count_underflow, score_bus.payload.count_underflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (score_bus.valid && score_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("normal_split_log_likelihood test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    random_burst_run(400);
    test_output_backpressure();
    test_register_extremes();
    test_random_settings();
    wait_drained();
    if (errors == 0)
      $display("normal_split_log_likelihood test passed");
    else
      $display("normal_split_log_likelihood test failed");
    $finish;
  end

endmodule
